### src/csq_pkg.sv
// Shared types and constants for the counting semaphore block.
// Holds request/response beat structs, codes, controller state and command types.
// No dependencies.
`default_nettype none

package csq_pkg;

  localparam int NUM_SEMS_DEF   = 8;
  localparam int WAIT_DEPTH_DEF = 32;

  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 3;
  localparam int COUNT_W  = 8;
  localparam int PID_W    = 5;
  localparam int STATUS_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [ACTION_W-1:0] ACT_CREATE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOCK   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_UNLOCK = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_NOP    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SEM      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL        = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_CREATED = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  sem_index;
    logic [COUNT_W-1:0]  initial_count;
    logic [PID_W-1:0]    caller_pid;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  assigned_index;
    logic                caller_blocked;
    logic                woken_valid;
    logic [PID_W-1:0]    woken_pid;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WAKE,
    ST_HOLD
  } state_t;

  typedef enum logic [1:0] {
    SRC_EXEC,
    SRC_WAKE,
    SRC_HOLD
  } load_src_t;

  typedef struct packed {
    logic      start;
    logic      exec;
    logic      wake;
    logic      load;
    load_src_t src;
  } cmd_t;

  typedef struct packed {
    logic wake_needed;
  } stat_t;

endpackage

`default_nettype wire

### src/csq_ctrl.sv
// Controller state machine for the counting semaphore block.
// Sequences record fetch, execute, waiter fetch and response load; owns rsp_valid.
// Depends on csq_pkg.
`default_nettype none

module csq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  input  wire csq_pkg::stat_t stat,
  output csq_pkg::cmd_t       cmd
);
  import csq_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.wake_needed) begin
          state_next = ST_WAKE;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_HOLD;
        end
      end
      ST_WAKE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '{start: 1'b0, exec: 1'b0, wake: 1'b0, load: 1'b0, src: SRC_HOLD};
    case (state)
      ST_IDLE: begin
        cmd.start = req_valid;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        cmd.src  = SRC_EXEC;
        cmd.load = !stat.wake_needed && out_free;
      end
      ST_WAKE: begin
        cmd.wake = 1'b1;
        cmd.src  = SRC_WAKE;
        cmd.load = out_free;
      end
      ST_HOLD: begin
        cmd.src  = SRC_HOLD;
        cmd.load = out_free;
      end
      default: begin
        cmd.src = SRC_HOLD;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/csq_dp.sv
// Datapath for the counting semaphore block: semaphore record memory,
// waiter memory, allocation counter, result and response registers.
// Depends on csq_pkg; driven by csq_ctrl commands.
`default_nettype none

module csq_dp #(
  parameter int NUM_SEMS   = csq_pkg::NUM_SEMS_DEF,
  parameter int WAIT_DEPTH = csq_pkg::WAIT_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire csq_pkg::req_t req,
  input  wire csq_pkg::cmd_t cmd,
  output csq_pkg::stat_t     stat,
  output csq_pkg::rsp_t      rsp
);
  import csq_pkg::*;

  localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int NW = $clog2(NUM_SEMS + 1);
  localparam int CW = (NW > INDEX_W) ? NW : INDEX_W;
  localparam int EW = (SW > INDEX_W) ? SW : INDEX_W;
  localparam int HW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int FW = $clog2(WAIT_DEPTH + 1);
  localparam int TOTAL = NUM_SEMS * WAIT_DEPTH;
  localparam int AW = (TOTAL > 1) ? $clog2(TOTAL) : 1;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [HW-1:0]      head;
    logic [FW-1:0]      fill;
  } rec_t;

  rec_t             rec_mem [NUM_SEMS];
  logic [PID_W-1:0] waiter_mem [TOTAL];

  rec_t             rec_q;
  req_t             req_q;
  logic [PID_W-1:0] wpid_q;
  logic [NW-1:0]    next_free;
  rsp_t             res;

  logic [SW-1:0]    rd_sem;
  logic [SW-1:0]    cur_sem;
  logic             created;
  logic             sems_left;

  rsp_t             exec_res;
  rsp_t             wake_res;
  rsp_t             load_res;
  logic             rec_we;
  logic [SW-1:0]    rec_waddr;
  rec_t             rec_wdata;
  logic             w_we;
  logic             w_re;
  logic [HW-1:0]    w_slot;
  logic [AW-1:0]    w_addr;
  logic             alloc;
  logic [HW:0]      tail_sum;
  logic [HW-1:0]    tail;
  logic [HW-1:0]    head_adv;

  assign rd_sem    = SW'(EW'(req.sem_index));
  assign cur_sem   = SW'(EW'(req_q.sem_index));
  assign created   = CW'(req_q.sem_index) < CW'(next_free);
  assign sems_left = next_free != NW'(NUM_SEMS);

  assign tail_sum = (HW + 1)'(rec_q.head) + (HW + 1)'(rec_q.fill);
  assign tail     = (tail_sum >= (HW + 1)'(WAIT_DEPTH))
                  ? HW'(tail_sum - (HW + 1)'(WAIT_DEPTH)) : HW'(tail_sum);
  assign head_adv = ((HW + 1)'(rec_q.head) + 1'b1 == (HW + 1)'(WAIT_DEPTH))
                  ? '0 : HW'(rec_q.head + 1'b1);

  always_comb begin
    exec_res         = '0;
    exec_res.status  = ST_OK;
    rec_we           = 1'b0;
    rec_waddr        = cur_sem;
    rec_wdata        = rec_q;
    w_we             = 1'b0;
    w_re             = 1'b0;
    w_slot           = tail;
    alloc            = 1'b0;
    stat.wake_needed = 1'b0;
    if (req_q.action == ACT_CREATE) begin
      if (!sems_left) begin
        exec_res.status = ST_NO_SEM;
      end else begin
        alloc                   = 1'b1;
        rec_we                  = 1'b1;
        rec_waddr               = SW'(next_free);
        rec_wdata.count         = req_q.initial_count;
        rec_wdata.head          = '0;
        rec_wdata.fill          = '0;
        exec_res.assigned_index = INDEX_W'(next_free);
      end
    end else if (req_q.action == ACT_LOCK || req_q.action == ACT_UNLOCK) begin
      if (!created) begin
        exec_res.status = ST_NOT_CREATED;
      end else if (req_q.action == ACT_LOCK) begin
        if (rec_q.count != '0) begin
          rec_we          = 1'b1;
          rec_wdata.count = rec_q.count - 1'b1;
        end else if (rec_q.fill == FW'(WAIT_DEPTH)) begin
          exec_res.status = ST_FULL;
        end else begin
          rec_we                  = 1'b1;
          rec_wdata.fill          = rec_q.fill + 1'b1;
          w_we                    = 1'b1;
          exec_res.caller_blocked = 1'b1;
        end
      end else begin
        if (rec_q.fill == '0) begin
          rec_we = 1'b1;
          if (rec_q.count != COUNT_MAX) begin
            rec_wdata.count = rec_q.count + 1'b1;
          end
        end else begin
          rec_we               = 1'b1;
          rec_wdata.head       = head_adv;
          rec_wdata.fill       = rec_q.fill - 1'b1;
          w_re                 = 1'b1;
          w_slot               = rec_q.head;
          exec_res.woken_valid = 1'b1;
          stat.wake_needed     = 1'b1;
        end
      end
    end
  end

  assign w_addr = AW'(cur_sem) * AW'(WAIT_DEPTH) + AW'(w_slot);

  always_comb begin
    wake_res           = res;
    wake_res.woken_pid = wpid_q;
  end

  always_comb begin
    case (cmd.src)
      SRC_EXEC: load_res = exec_res;
      SRC_WAKE: load_res = wake_res;
      SRC_HOLD: load_res = res;
      default:  load_res = res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_q <= req;
      rec_q <= rec_mem[rd_sem];
    end
    if (cmd.exec && rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && w_we) begin
      waiter_mem[w_addr] <= req_q.caller_pid;
    end
    if (cmd.exec && w_re) begin
      wpid_q <= waiter_mem[w_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_free <= '0;
    end else if (cmd.exec && alloc) begin
      next_free <= next_free + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res <= exec_res;
    end else if (cmd.wake) begin
      res <= wake_res;
    end
    if (cmd.load) begin
      rsp <= load_res;
    end
  end

endmodule

`default_nettype wire

### src/counting_semaphore_wait_queues_top.sv
// Counting semaphores with FIFO wait queues. A request is taken only while the
// block is idle; its response beat is loaded in the execute state for create, lock
// and unlock with no waiter, in the wake state for an unlock that wakes a waiter,
// or in the hold state while the output stalls. The load follows the registered
// read of the per-semaphore record memory (count, head, fill) and, on a wake, the
// registered read of the waiter memory. The next request is taken the cycle after
// the response is loaded, never earlier; the response register lets a request be
// taken while the previous response still waits, and a stalled response holds
// the block before its own load. No clearing pass follows reset.
// Depends on csq_pkg, csq_ctrl and csq_dp.
`default_nettype none

module counting_semaphore_wait_queues_top #(
  parameter int NUM_SEMS   = csq_pkg::NUM_SEMS_DEF,
  parameter int WAIT_DEPTH = csq_pkg::WAIT_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire csq_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output csq_pkg::rsp_t      rsp
);
  import csq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  csq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  csq_dp #(
    .NUM_SEMS   (NUM_SEMS),
    .WAIT_DEPTH (WAIT_DEPTH)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule

`default_nettype wire
